/* design/lr_pkg.sv */
// Package for the line rasterizer: widths, coordinate mask and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package lr_pkg;

    localparam int COORD_BITS = 6;          // coordinate bits actually used
    localparam int PIX_W      = 6;          // port width of a coordinate
    localparam int MAJOR_W    = PIX_W + 1;  // major position counts one past 63
    localparam int STEP2_W    = PIX_W + 2;  // twice the minor span
    localparam int ERR_W      = PIX_W + 3;  // signed error accumulator
    localparam int WIDTH_W    = 7;          // surface_width register
    localparam int ADDR_W     = 12;         // linear pixel address
    localparam int COLOR_W    = 32;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [PIX_W-1:0]   COORD_MASK    = PIX_W'((1 << COORD_BITS) - 1);
    localparam logic [WIDTH_W-1:0] WIDTH_RESET   = WIDTH_W'(64);
    localparam logic [PADDR_W-1:2] REG_SURF_WIDTH = '0;

    typedef struct packed {
        logic load;   // capture a new line and set up the walk
        logic step;   // emit the current pixel and advance
    } lr_cmd_t;

    typedef struct packed {
        logic at_end; // current pixel is the last one of the line
    } lr_status_t;

endpackage

/* design/line_rasterizer_core.sv */
// Line rasterizer top level: APB register, controller and datapath.
// Depends on lr_pkg, lr_ctrl, lr_datapath.
//
//   channel | handshake                | payload
//   --------+--------------------------+---------------------------------------
//   in      | in_valid / in_stall      | start_x start_y end_x end_y color
//   out     | out_valid / out_stall    | pixel_x pixel_y pixel_address
//           |                          | pixel_color last
//   cfg     | psel penable pwrite      | paddr pwdata prdata (surface_width @0)
//
// A line is loaded in a setup step, then walked at one pixel per cycle
// by the single Bresenham step unit while the output is not stalled.
// in_stall is high from the cycle after a line is accepted until its last
// pixel enters the output register. out_stall holds the walk in place.
// Reset clears the controller and sets surface_width to 64.
`timescale 1ns / 1ps

module line_rasterizer_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lr_pkg::PADDR_W-1:0]   paddr,
    input  logic [lr_pkg::PDATA_W-1:0]   pwdata,
    output logic [lr_pkg::PDATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [lr_pkg::PIX_W-1:0]     start_x,
    input  logic [lr_pkg::PIX_W-1:0]     start_y,
    input  logic [lr_pkg::PIX_W-1:0]     end_x,
    input  logic [lr_pkg::PIX_W-1:0]     end_y,
    input  logic [lr_pkg::COLOR_W-1:0]   color,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [lr_pkg::PIX_W-1:0]     pixel_x,
    output logic [lr_pkg::PIX_W-1:0]     pixel_y,
    output logic [lr_pkg::ADDR_W-1:0]    pixel_address,
    output logic [lr_pkg::COLOR_W-1:0]   pixel_color,
    output logic                         last
);

    logic [lr_pkg::WIDTH_W-1:0] surface_width_reg;
    logic                       width_sel;
    lr_pkg::lr_cmd_t            cmd;
    lr_pkg::lr_status_t         status;

    assign pready    = 1'b1;
    assign width_sel = (paddr[lr_pkg::PADDR_W-1:2] == lr_pkg::REG_SURF_WIDTH);
    assign prdata    = width_sel ? lr_pkg::PDATA_W'(surface_width_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surface_width_reg <= lr_pkg::WIDTH_RESET;
        end
        else if (psel && penable && pwrite && pready && width_sel)
        begin
            surface_width_reg <= pwdata[lr_pkg::WIDTH_W-1:0];
        end
    end

    lr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lr_datapath u_datapath
    (
        .clk           (clk),
        .cmd           (cmd),
        .status        (status),
        .surface_width (surface_width_reg),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .color         (color),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .last          (last)
    );

endmodule

/* design/lr_ctrl.sv */
// Line rasterizer controller: idle/run state machine, input stall and
// output valid. Depends on lr_pkg.
`timescale 1ns / 1ps

module lr_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  lr_pkg::lr_status_t status,
    output lr_pkg::lr_cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_stall_reg, in_stall_next;
    logic   slot_free;

    // output register can take a pixel when empty or being drained this cycle
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (slot_free)
                begin
                    cmd.step       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        in_stall_next = (state_next == ST_RUN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            in_stall_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            in_stall_reg  <= in_stall_next;
        end
    end

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

endmodule

/* design/lr_datapath.sv */
// Line rasterizer datapath: line setup, Bresenham walk registers, address
// multiply and the output register. Depends on lr_pkg.
`timescale 1ns / 1ps

module lr_datapath
(
    input  logic                         clk,
    input  lr_pkg::lr_cmd_t              cmd,
    output lr_pkg::lr_status_t           status,
    input  logic [lr_pkg::WIDTH_W-1:0]   surface_width,
    input  logic [lr_pkg::PIX_W-1:0]     start_x,
    input  logic [lr_pkg::PIX_W-1:0]     start_y,
    input  logic [lr_pkg::PIX_W-1:0]     end_x,
    input  logic [lr_pkg::PIX_W-1:0]     end_y,
    input  logic [lr_pkg::COLOR_W-1:0]   color,
    output logic [lr_pkg::PIX_W-1:0]     pixel_x,
    output logic [lr_pkg::PIX_W-1:0]     pixel_y,
    output logic [lr_pkg::ADDR_W-1:0]    pixel_address,
    output logic [lr_pkg::COLOR_W-1:0]   pixel_color,
    output logic                         last
);

    localparam int PIX_W   = lr_pkg::PIX_W;
    localparam int MAJOR_W = lr_pkg::MAJOR_W;
    localparam int STEP2_W = lr_pkg::STEP2_W;
    localparam int ERR_W   = lr_pkg::ERR_W;
    localparam int PROD_W  = PIX_W + lr_pkg::WIDTH_W;
    localparam int ADDR_W  = lr_pkg::ADDR_W;

    // walk state
    logic [MAJOR_W-1:0]         major_pos_reg, major_pos_next;
    logic [PIX_W-1:0]           minor_pos_reg, minor_pos_next;
    logic [PIX_W-1:0]           major_end_reg;
    logic signed [ERR_W-1:0]    error_acc_reg, error_acc_next;
    logic [MAJOR_W-1:0]         major_span_reg;
    logic [STEP2_W-1:0]         minor_step_twice_reg;
    logic                       minor_down_reg;
    logic                       axes_swapped_reg;
    logic [lr_pkg::COLOR_W-1:0] color_reg;

    // output register
    logic [PIX_W-1:0]           pixel_x_reg, pixel_y_reg;
    logic [ADDR_W-1:0]          pixel_address_reg;
    logic [lr_pkg::COLOR_W-1:0] pixel_color_reg;
    logic                       last_reg;

    // setup
    logic [PIX_W-1:0] x0, y0, x1, y1, dx, dy, minor_span;
    logic [PIX_W-1:0] a0, b0, a1, b1, lo_a, lo_b, hi_a, hi_b;
    logic             steep;

    // step
    logic [PIX_W-1:0]        px, py;
    logic [PROD_W-1:0]       prod;
    logic signed [ERR_W-1:0] err_sum;
    logic                    minor_move;

    always_comb
    begin
        x0 = start_x & lr_pkg::COORD_MASK;
        y0 = start_y & lr_pkg::COORD_MASK;
        x1 = end_x & lr_pkg::COORD_MASK;
        y1 = end_y & lr_pkg::COORD_MASK;
        dx = (x1 > x0) ? (x1 - x0) : (x0 - x1);
        dy = (y1 > y0) ? (y1 - y0) : (y0 - y1);
        steep = dy > dx;
        a0 = steep ? y0 : x0;
        b0 = steep ? x0 : y0;
        a1 = steep ? y1 : x1;
        b1 = steep ? x1 : y1;
        // order the endpoints so the major coordinate increases
        if (a0 > a1)
        begin
            lo_a = a1; lo_b = b1; hi_a = a0; hi_b = b0;
        end
        else
        begin
            lo_a = a0; lo_b = b0; hi_a = a1; hi_b = b1;
        end
        minor_span = (hi_b > lo_b) ? (hi_b - lo_b) : (lo_b - hi_b);
    end

    always_comb
    begin
        px = axes_swapped_reg ? minor_pos_reg : major_pos_reg[PIX_W-1:0];
        py = axes_swapped_reg ? major_pos_reg[PIX_W-1:0] : minor_pos_reg;
        prod = PROD_W'(py) * PROD_W'(surface_width);
        err_sum = error_acc_reg + $signed({1'b0, minor_step_twice_reg});
        minor_move = err_sum > $signed({2'b00, major_span_reg});
        major_pos_next = major_pos_reg + MAJOR_W'(1);
        if (minor_move)
        begin
            minor_pos_next = minor_down_reg ? (minor_pos_reg - PIX_W'(1))
                                            : (minor_pos_reg + PIX_W'(1));
            error_acc_next = err_sum - $signed({1'b0, major_span_reg, 1'b0});
        end
        else
        begin
            minor_pos_next = minor_pos_reg;
            error_acc_next = err_sum;
        end
    end

    assign status.at_end = (major_pos_reg == {1'b0, major_end_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            axes_swapped_reg     <= steep;
            major_pos_reg        <= {1'b0, lo_a};
            minor_pos_reg        <= lo_b;
            major_end_reg        <= hi_a;
            major_span_reg       <= {1'b0, hi_a - lo_a};
            minor_step_twice_reg <= {1'b0, minor_span, 1'b0};
            minor_down_reg       <= !(hi_b > lo_b);
            error_acc_reg        <= '0;
            color_reg            <= color;
        end
        else if (cmd.step)
        begin
            major_pos_reg <= major_pos_next;
            minor_pos_reg <= minor_pos_next;
            error_acc_reg <= error_acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            pixel_x_reg       <= px;
            pixel_y_reg       <= py;
            pixel_address_reg <= prod[ADDR_W-1:0] + ADDR_W'(px);
            pixel_color_reg   <= color_reg;
            last_reg          <= status.at_end;
        end
    end

    assign pixel_x       = pixel_x_reg;
    assign pixel_y       = pixel_y_reg;
    assign pixel_address = pixel_address_reg;
    assign pixel_color   = pixel_color_reg;
    assign last          = last_reg;

endmodule
